// ===== rtl/core/positional_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// positional_list_engine assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and default sizes of the positional list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

    localparam int PLE_CAPACITY   = 32;
    localparam int PLE_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_INSERT     = 3'd3,
        MODE_READ       = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_HOLD = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic apply;
        logic capture;
    } ctrl_cmd_t;

endpackage

// ===== rtl/core/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Handshake controller: accepts a transfer, holds the result until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_ctrl
    import ple_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        take;

    assign take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    state_next = CS_HOLD;
                end
            end
            CS_HOLD: begin
                if (m_ready && !s_valid) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
            end
            CS_HOLD: begin
                s_ready = m_ready;
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.apply   = take;
        cmd.capture = take;
    end

endmodule

// ===== rtl/core/ple_datapath.sv =====
// ----------------------------------------------------------------------------
// ple_datapath
// Register cell array that shifts or holds per cell, entry count, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY   = PLE_CAPACITY,
    parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    input  logic [2:0]         s_mode,
    input  logic [5:0]         s_position,
    input  logic signed [31:0] s_value,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic [5:0]         m_entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (IW > 6) ? IW : 6;
    localparam int MW = ((CW > 6) ? CW : 6) + 1;

    logic [DATA_WIDTH-1:0] cells_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] cells_next [CAPACITY];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic [1:0]            status_reg;
    logic signed [31:0]    rd_reg;
    logic [5:0]            cnt_out_reg;

    logic [DATA_WIDTH-1:0] val_store;
    logic [PW-1:0]         pos_m1;
    logic [IW-1:0]         pos_idx;
    logic [MW-1:0]         pos_w;
    logic [MW-1:0]         cnt_w;
    logic                  full;
    logic                  bad_ins;
    logic                  bad_rd;
    logic                  do_ins;
    logic                  do_pop;
    logic [IW-1:0]         ins_idx;
    status_t               status_next;
    logic signed [31:0]    rd_next;

    assign val_store = DATA_WIDTH'($unsigned(s_value));
    assign pos_m1    = PW'(s_position) - PW'(1);
    assign pos_idx   = pos_m1[IW-1:0];
    assign pos_w     = MW'(s_position);
    assign cnt_w     = MW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign bad_ins   = (s_position == 6'd0) || (pos_w > cnt_w + MW'(1));
    assign bad_rd    = (s_position == 6'd0) || (pos_w > cnt_w);

    always_comb begin
        status_next = STAT_OK;
        do_ins      = 1'b0;
        do_pop      = 1'b0;
        ins_idx     = '0;
        rd_next     = '0;
        case (mode_t'(s_mode))
            MODE_PUSH_FRONT: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_idx = count_reg[IW-1:0];
                end
            end
            MODE_POP_FRONT: begin
                if (count_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else begin
                    do_pop = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (bad_ins) begin
                    status_next = STAT_BADPOS;
                end else if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_idx = pos_idx;
                end
            end
            MODE_READ: begin
                if (bad_rd) begin
                    status_next = STAT_BADPOS;
                end else begin
                    rd_next = 32'(cells_reg[pos_idx]);
                end
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_cell;
        logic [DATA_WIDTH-1:0] succ_cell;

        if (i == 0) begin : g_first
            assign prev_cell = cells_reg[i];
        end else begin : g_rest
            assign prev_cell = cells_reg[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign succ_cell = cells_reg[i];
        end else begin : g_inner
            assign succ_cell = cells_reg[i+1];
        end

        always_comb begin
            cells_next[i] = cells_reg[i];
            if (do_ins) begin
                if (ins_idx == IW'(i)) begin
                    cells_next[i] = val_store;
                end else if (ins_idx < IW'(i)) begin
                    cells_next[i] = prev_cell;
                end
            end else if (do_pop) begin
                cells_next[i] = succ_cell;
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.apply) begin
                cells_reg[i] <= cells_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.apply) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            status_reg  <= status_next;
            rd_reg      <= rd_next;
            cnt_out_reg <= 6'(count_next);
        end
    end

    assign m_status      = status_reg;
    assign m_read_value  = rd_reg;
    assign m_entry_count = cnt_out_reg;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Result: valid in the cycle after its input transfer.
// Throughput: one item per cycle while m_ready stays high; every cell of the
// register array shifts or holds on each transfer. A waiting result holds off
// the input, and the next transfer lands in the cycle the result is taken.
// Reset: aresetn (synchronous) clears the entry count and output valid;
// cell contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list with push, pop, positional insert and positional read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY   = PLE_CAPACITY,
    parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic [5:0]         s_position,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic [5:0]         m_entry_count
);

    ctrl_cmd_t cmd;

    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ple_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_mode        (s_mode),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count)
    );

endmodule

// ===== rtl/core/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker
// Port-level assertions for the positional list engine, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_engine_assert.svh"

module ple_checker
    import ple_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic signed [31:0] m_read_value,
    input logic [5:0]         m_entry_count
);

    `PLE_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_read_value) && $stable(m_entry_count), "result changed while stalled")
    `PLE_ASSERT_NOW(a_ready_when_free, !m_valid, s_ready, "input not ready with no pending result")
    `PLE_ASSERT_NOW(a_read_zero_on_error, m_valid && (m_status != STAT_OK), m_read_value == '0, "nonzero read value on error status")
    `PLE_ASSERT_NOW(a_empty_count, m_valid && (m_status == STAT_EMPTY), m_entry_count == '0, "empty status with nonzero count")

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
